// ===== hdl/middle_out_queue_top_assert.svh =====
// assertion macros for the middle-out queue
`ifndef MIDDLE_OUT_QUEUE_TOP_ASSERT_SVH
`define MIDDLE_OUT_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MOQ_CHECK(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MOQ_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mdq_pkg.sv =====
`default_nettype none

package mdq_pkg;

    localparam int CAPACITY   = 16;
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int SUM_W      = $clog2(2 * HALF_DEPTH + 1);
    localparam int IDX_W      = CNT_W + 1;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 5;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
        logic                     has_middle;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/mdq_core.sv =====
`default_nettype none

module mdq_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step,
    input  wire mdq_pkg::op_t                         op,
    input  wire logic signed [mdq_pkg::DATA_W-1:0]    push_value,
    output mdq_pkg::result_t                          result
);

    // front half: stack with the middle element on top
    logic signed [mdq_pkg::DATA_W-1:0] stack_reg [mdq_pkg::HALF_DEPTH];
    // back half: ring with the element after the middle at its head
    logic signed [mdq_pkg::DATA_W-1:0] ring_reg [mdq_pkg::HALF_DEPTH];

    logic [mdq_pkg::CNT_W-1:0] fc_reg, fc_next;
    logic [mdq_pkg::CNT_W-1:0] bc_reg, bc_next;
    logic [mdq_pkg::PTR_W-1:0] rh_reg, rh_next;

    logic [mdq_pkg::CNT_W-1:0] fc_m1;
    logic [mdq_pkg::CNT_W-1:0] bc_inc;
    logic [mdq_pkg::PTR_W-1:0] top_idx;
    logic [mdq_pkg::PTR_W-1:0] tail_idx;
    logic [mdq_pkg::PTR_W-1:0] rh_inc;
    logic [mdq_pkg::IDX_W-1:0] tail_sum;
    logic [mdq_pkg::IDX_W-1:0] tail_wrap;
    logic [mdq_pkg::SUM_W-1:0] total;
    logic [mdq_pkg::SUM_W-1:0] total_next;
    logic signed [mdq_pkg::DATA_W-1:0] top_val;
    logic signed [mdq_pkg::DATA_W-1:0] head_val;
    logic signed [mdq_pkg::DATA_W-1:0] moved_val;
    logic full;
    logic popped;
    logic moved_to_top;

    logic                              st_we;
    logic [mdq_pkg::PTR_W-1:0]         st_waddr;
    logic signed [mdq_pkg::DATA_W-1:0] st_wdata;
    logic                              rg_we;
    mdq_pkg::status_t                  status;

    assign fc_m1    = fc_reg - 1'b1;
    assign bc_inc   = bc_reg + 1'b1;
    assign top_idx  = mdq_pkg::PTR_W'(fc_m1);
    assign top_val  = stack_reg[top_idx];
    assign head_val = ring_reg[rh_reg];
    assign rh_inc   = (rh_reg == mdq_pkg::PTR_W'(mdq_pkg::HALF_DEPTH - 1))
                      ? '0 : rh_reg + 1'b1;

    // tail slot, ring_head + back_count wrapped once
    assign tail_sum  = mdq_pkg::IDX_W'(rh_reg) + mdq_pkg::IDX_W'(bc_reg);
    assign tail_wrap = (tail_sum >= mdq_pkg::IDX_W'(mdq_pkg::HALF_DEPTH))
                       ? tail_sum - mdq_pkg::IDX_W'(mdq_pkg::HALF_DEPTH) : tail_sum;
    assign tail_idx  = mdq_pkg::PTR_W'(tail_wrap);

    assign total = mdq_pkg::SUM_W'(fc_reg) + mdq_pkg::SUM_W'(bc_reg);
    assign full  = (total >= mdq_pkg::SUM_W'(mdq_pkg::CAPACITY))
                   || (bc_reg >= mdq_pkg::CNT_W'(mdq_pkg::HALF_DEPTH));

    always_comb begin
        fc_next      = fc_reg;
        bc_next      = bc_reg;
        rh_next      = rh_reg;
        st_we        = 1'b0;
        st_waddr     = top_idx;
        st_wdata     = head_val;
        rg_we        = 1'b0;
        status       = mdq_pkg::ST_OK;
        popped       = 1'b0;
        moved_to_top = 1'b0;
        moved_val    = head_val;
        unique case (op)
            mdq_pkg::OP_PUSH: begin
                if (full) begin
                    status = mdq_pkg::ST_PUSH_FULL;
                end else begin
                    rg_we = 1'b1;
                    if ((bc_inc > fc_reg) && (fc_reg < mdq_pkg::CNT_W'(mdq_pkg::HALF_DEPTH)))
                    begin
                        // with an empty ring the new value goes straight to the stack
                        st_we        = 1'b1;
                        st_waddr     = mdq_pkg::PTR_W'(fc_reg);
                        st_wdata     = (bc_reg == '0) ? push_value : head_val;
                        moved_to_top = 1'b1;
                        moved_val    = st_wdata;
                        fc_next      = fc_reg + 1'b1;
                        rh_next      = rh_inc;
                    end else begin
                        bc_next = bc_inc;
                    end
                end
            end
            mdq_pkg::OP_POP: begin
                if (fc_reg == '0) begin
                    status = mdq_pkg::ST_POP_EMPTY;
                end else begin
                    popped = 1'b1;
                    if ((bc_reg > fc_m1) && (bc_reg != '0)) begin
                        // ring head replaces the popped top
                        st_we   = 1'b1;
                        bc_next = bc_reg - 1'b1;
                        rh_next = rh_inc;
                    end else begin
                        fc_next = fc_m1;
                    end
                end
            end
            mdq_pkg::OP_CLEAR: begin
                fc_next = '0;
                bc_next = '0;
                rh_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign total_next = mdq_pkg::SUM_W'(fc_next) + mdq_pkg::SUM_W'(bc_next);

    always_comb begin
        result.status     = status;
        result.count      = mdq_pkg::COUNT_W'(total_next);
        result.has_middle = (fc_next != '0);
        if (popped) begin
            result.value = top_val;
        end else if (fc_next == '0) begin
            result.value = '0;
        end else if (moved_to_top) begin
            result.value = moved_val;
        end else begin
            result.value = top_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= '0;
            bc_reg <= '0;
            rh_reg <= '0;
        end else if (step) begin
            fc_reg <= fc_next;
            bc_reg <= bc_next;
            rh_reg <= rh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && st_we) begin
            stack_reg[st_waddr] <= st_wdata;
        end
        if (step && rg_we) begin
            ring_reg[tail_idx] <= push_value;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/middle_out_queue_top.sv =====
// channel   dir   bits  fields (lsb first)
// s_        in    40    op[1:0], push_value[33:2], zero pad [39:34]
// m_        out   40    value[31:0], status[33:32], count[38:34], has_middle[39]
//
// one beat per cycle sustained while the output is not stalled; a beat passes the input
// register, then the queue update into the result register
// the queue update for a beat is done in the cycle it leaves the input register
// aresetn (synchronous) empties the queue; storage contents are not cleared
// a stalled output holds its beat, and the input register can still take one more
`default_nettype none

`include "middle_out_queue_top_assert.svh"

module middle_out_queue_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // op[1:0], push_value[33:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // value, status, count, has_middle
);

    logic                               in_valid_reg;
    mdq_pkg::op_t                       op_reg;
    logic signed [mdq_pkg::DATA_W-1:0]  value_reg;
    logic                               out_valid_reg;
    mdq_pkg::result_t                   out_reg;
    mdq_pkg::result_t                   result;
    logic                               advance;
    logic                               step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    mdq_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .op         (op_reg),
        .push_value (value_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= mdq_pkg::op_t'(s_tdata[1:0]);
            value_reg <= s_tdata[33:2];
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.has_middle, out_reg.count, out_reg.status, out_reg.value};

    `MOQ_CHECK(a_count_range, aclk, aresetn, m_tvalid,
        m_tdata[38:34] <= 5'(mdq_pkg::CAPACITY), "result count above capacity")
    `MOQ_CHECK(a_middle_flag, aclk, aresetn, m_tvalid,
        m_tdata[39] == (m_tdata[38:34] != 5'd0), "has_middle disagrees with count")
    `MOQ_CHECK(a_empty_pop, aclk, aresetn, m_tvalid && (out_reg.status == mdq_pkg::ST_POP_EMPTY),
        (m_tdata[38:34] == 5'd0) && (m_tdata[31:0] == 32'd0), "failed pop on nonempty queue")
    `MOQ_CHECK_NEXT(a_result_loads, aclk, aresetn, step,
        out_valid_reg, "processed beat did not reach the result register")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // op code 3 is left undecoded by the block and acts as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_DRAIN_CYCLES = 8;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] push_value;
    } queue_cmd_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // op[1:0], push_value[33:2]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // value[31:0], status[33:32], count[38:34], has_middle[39]

    middle_out_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    queue_cmd_t          cmd_q[$];
    mdq_pkg::result_t    result_q[$];
    queue_cmd_t          next_cmd;
    queue_cmd_t          seen_cmd;
    mdq_pkg::result_t    want;
    logic                s_fire;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  error_count;
    int                  idle_cycles;

    // shadow of the queue halves
    logic [31:0] front_stack [mdq_pkg::HALF_DEPTH];
    logic [31:0] back_ring [mdq_pkg::HALF_DEPTH];
    int          front_cnt;
    int          back_cnt;
    int          ring_head;

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        $display("mismatch on %s: got %h, expected %h", what, got, exp_val);
        error_count++;
    endtask

    // move the ring head onto the stack once the back half outgrows the front
    function automatic void shift_ring_to_stack();
        if (back_cnt > front_cnt && back_cnt > 0 && front_cnt < mdq_pkg::HALF_DEPTH) begin
            front_stack[front_cnt] = back_ring[ring_head];
            front_cnt++;
            ring_head = (ring_head + 1) % mdq_pkg::HALF_DEPTH;
            back_cnt--;
        end
    endfunction

    function automatic mdq_pkg::result_t predict_queue_op(queue_cmd_t c);
        mdq_pkg::result_t r;
        logic             popped;
        r.value  = '0;
        r.status = mdq_pkg::ST_OK;
        popped   = 1'b0;
        case (c.op)
            mdq_pkg::OP_PUSH: begin
                if (front_cnt + back_cnt >= mdq_pkg::CAPACITY
                    || back_cnt >= mdq_pkg::HALF_DEPTH) begin
                    r.status = mdq_pkg::ST_PUSH_FULL;
                end else begin
                    back_ring[(ring_head + back_cnt) % mdq_pkg::HALF_DEPTH] = c.push_value;
                    back_cnt++;
                    shift_ring_to_stack();
                end
            end
            mdq_pkg::OP_POP: begin
                if (front_cnt == 0) begin
                    r.status = mdq_pkg::ST_POP_EMPTY;
                end else begin
                    front_cnt--;
                    r.value = front_stack[front_cnt];
                    popped  = 1'b1;
                    shift_ring_to_stack();
                end
            end
            mdq_pkg::OP_CLEAR: begin
                front_cnt = 0;
                back_cnt  = 0;
                ring_head = 0;
            end
            default: ;
        endcase
        if (!popped && front_cnt > 0)
            r.value = front_stack[front_cnt - 1];
        r.count      = mdq_pkg::COUNT_W'(front_cnt + back_cnt);
        r.has_middle = (front_cnt > 0);
        return r;
    endfunction

    task automatic add_cmd(logic [1:0] op, logic [31:0] v);
        queue_cmd_t c;
        c.op         = op;
        c.push_value = v;
        cmd_q.push_back(c);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // runs of push-heavy, balanced and pop-heavy traffic so the queue fills and drains
    task automatic add_random_cmds(int n);
        int left;
        int run_len;
        int push_pct;
        int r;
        left = n;
        while (left > 0) begin
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 15;
            endcase
            run_len = $urandom_range(40, 8);
            while (run_len > 0 && left > 0) begin
                r = $urandom_range(99);
                if (r < 2)
                    add_cmd(mdq_pkg::OP_CLEAR, $urandom);
                else if (r < 4)
                    add_cmd(OP_NOP, $urandom);
                else if ($urandom_range(99) < push_pct)
                    add_cmd(mdq_pkg::OP_PUSH, pick_value());
                else
                    add_cmd(mdq_pkg::OP_POP, $urandom);
                run_len--;
                left--;
            end
        end
    endtask

    task automatic add_directed_cmds();
        add_cmd(mdq_pkg::OP_PUSH, 32'h8000_0000);
        add_cmd(mdq_pkg::OP_PUSH, 32'h7fff_ffff);
        add_cmd(OP_NOP, 32'h1234_5678);
        add_cmd(mdq_pkg::OP_POP, 32'hffff_ffff);
        add_cmd(mdq_pkg::OP_PUSH, 32'hffff_ffff);
        add_cmd(mdq_pkg::OP_CLEAR, 32'h0);
        add_cmd(mdq_pkg::OP_POP, 32'h0);
        add_cmd(OP_NOP, 32'hffff_ffff);
        // fill to capacity, then one push too many
        for (int i = 0; i < mdq_pkg::CAPACITY; i++)
            add_cmd(mdq_pkg::OP_PUSH, (i % 2) ? 32'haaaa_aaaa : 32'h5555_5555);
        add_cmd(mdq_pkg::OP_PUSH, 32'h0bad_0bad);
    endtask

    task automatic wait_until_drained();
        while (cmd_q.size() != 0 || s_tvalid || result_q.size() != 0)
            @(negedge aclk);
    endtask

    // input driver: new beats change on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_fire) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, next_cmd.push_value, next_cmd.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on accepted input beats, check accepted output beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire      <= 1'b0;
            idle_cycles <= 0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                seen_cmd.op         = s_tdata[1:0];
                seen_cmd.push_value = s_tdata[33:2];
                result_q.push_back(predict_queue_op(seen_cmd));
            end
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("value", m_tdata[31:0], want.value);
                    if (m_tdata[33:32] !== want.status)
                        report_mismatch("status", {30'd0, m_tdata[33:32]}, {30'd0, want.status});
                    if (m_tdata[38:34] !== want.count)
                        report_mismatch("count", {27'd0, m_tdata[38:34]}, {27'd0, want.count});
                    if (m_tdata[39] !== want.has_middle)
                        report_mismatch("has_middle", {31'd0, m_tdata[39]},
                                        {31'd0, want.has_middle});
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        s_fire         = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        idle_cycles    = 0;
        front_cnt      = 0;
        back_cnt       = 0;
        ring_head      = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // each phase starts only once every result of the last one is in
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (phase == 0)
                add_directed_cmds();
            add_random_cmds(phase == 0 ? 350 : 375);
            wait_until_drained();
        end

        repeat (END_DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
